FILE: rtl/core/sidc_pkg.sv
// Package for the signed integer to decimal text converter.
// Holds the width constants, ASCII codes, controller states and the
// command/status structs shared by the controller and the datapath.
package sidc_pkg;

  // Width of the integer that is converted (8 to 64)
  localparam int unsigned VALUE_WIDTH = 64;
  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int unsigned DIGITS      = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int unsigned BCD_W       = DIGITS * 4;
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DIG_CNT_W   = $clog2(DIGITS + 1);

  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new number and form its magnitude
    logic conv;        // one shift-and-adjust step of the binary to BCD loop
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bit_last;    // final conversion step is in progress
    logic top_zero;    // most significant remaining digit is zero
    logic dig_one;     // one digit remains
    logic neg;         // number is negative
    logic slot_free;   // output register can take a character
  } sts_t;

endpackage

FILE: rtl/core/sidc_if.sv
// Handshake channels of the converter: integer in, characters out.
// Depends on nothing; payload widths follow the field definitions.
interface sidc_num_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sidc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last;

  modport source (output valid, output text_char, output last, input ready);
  modport sink   (input valid, input text_char, input last, output ready);
endinterface

FILE: rtl/core/sidc_ctrl.sv
// Controller of the converter: sequences load, conversion, zero skipping
// and character output. Depends on sidc_pkg.
module sidc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sidc_pkg::sts_t sts_i,
  output sidc_pkg::cmd_t cmd_o
);
  import sidc_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CONV;
      end
      ST_CONV: begin
        if (sts_i.bit_last) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts_i.top_zero || sts_i.dig_one) begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.slot_free) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.slot_free && sts_i.dig_one) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV: cmd_o.conv       = 1'b1;
      ST_SKIP: cmd_o.skip       = sts_i.top_zero && !sts_i.dig_one;
      ST_SIGN: cmd_o.emit_sign  = sts_i.slot_free;
      ST_EMIT: cmd_o.emit_digit = sts_i.slot_free;
      default: cmd_o            = '0;
    endcase
  end

endmodule

FILE: rtl/core/sidc_dp.sv
// Datapath of the converter: magnitude, bit-serial binary to BCD
// conversion, digit shifting and the output register. Depends on sidc_pkg.
module sidc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [63:0]  number_i,
  input  sidc_pkg::cmd_t      cmd_i,
  output sidc_pkg::sts_t      sts_o,
  sidc_char_if.source         char_o
);
  import sidc_pkg::*;

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] value;
  logic [BCD_W-1:0]       bcd_adj;
  logic [3:0]             top_digit;
  logic                   slot_free;

  assign value     = number_i[VALUE_WIDTH-1:0];
  assign top_digit = bcd_q[BCD_W-1 -: 4];
  assign slot_free = !out_valid_q || char_o.ready;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
                                                    : bcd_q[i*4 +: 4];
    end
  end

  // Work registers
  always_comb begin
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    bit_cnt_d = bit_cnt_q;
    dig_cnt_d = dig_cnt_q;
    neg_d     = neg_q;
    if (cmd_i.load) begin
      neg_d     = value[VALUE_WIDTH-1];
      mag_d     = value[VALUE_WIDTH-1] ? (~value) + VALUE_WIDTH'(1) : value;
      bcd_d     = '0;
      bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH);
      dig_cnt_d = DIG_CNT_W'(DIGITS);
    end else if (cmd_i.conv) begin
      bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
      mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - BIT_CNT_W'(1);
    end else if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d     = {bcd_q[BCD_W-5:0], 4'd0};
      dig_cnt_d = dig_cnt_q - DIG_CNT_W'(1);
    end
  end

  // Output register: load a character or drop it once transferred
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (cmd_i.emit_sign) begin
      out_valid_d = 1'b1;
      out_char_d  = ASCII_MINUS;
      out_last_d  = 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_valid_d = 1'b1;
      out_char_d  = ASCII_ZERO + {4'd0, top_digit};
      out_last_d  = (dig_cnt_q == DIG_CNT_W'(1));
    end else if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mag_q       <= mag_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    bcd_q      <= bcd_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.bit_last  = (bit_cnt_q == BIT_CNT_W'(1));
  assign sts_o.top_zero  = (top_digit == 4'd0);
  assign sts_o.dig_one   = (dig_cnt_q == DIG_CNT_W'(1));
  assign sts_o.neg       = neg_q;
  assign sts_o.slot_free = slot_free;

  assign char_o.valid     = out_valid_q;
  assign char_o.text_char = out_char_q;
  assign char_o.last      = out_last_q;

endmodule

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII text, one character per transfer.
// Per item: an accept step, the bit-serial BCD loop over all VALUE_WIDTH bits,
// a pass dropping leading zeros, then one character a cycle (sign included)
// while the sink keeps up.
// A new number is taken only once the previous one's last character is loaded.
// Reset is asynchronous, active low; it clears control state, no clearing pass.
module signed_int_to_decimal_ascii (
  input  logic        clk_i,
  input  logic        rst_ni,
  sidc_num_if.sink    num_i,
  sidc_char_if.source char_o
);
  import sidc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign num_i.ready = in_ready;

  sidc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (num_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sidc_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (num_i.number),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .char_o   (char_o)
  );

endmodule

FILE: rtl/core/sidc_checker.sv
// Port-level checks on the converter, bound to the top level.
// Depends on sidc_pkg for the ASCII codes.
module sidc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] text_char_i,
  input logic       last_i
);
  import sidc_pkg::*;

  // Hold the character while the sink stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(text_char_i) && $stable(last_i))
    else $error("character changed or dropped under stall");

  // Take no second number straight after a transfer in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer in");

  // Only a sign or a digit leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> text_char_i == ASCII_MINUS ||
                    (text_char_i >= ASCII_ZERO && text_char_i <= ASCII_ZERO + 8'd9))
    else $error("character is neither sign nor digit");

  // A sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && text_char_i == ASCII_MINUS |-> !last_i)
    else $error("sign marked as last");

endmodule

bind signed_int_to_decimal_ascii sidc_checker u_sidc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (num_i.valid),
  .in_ready_i  (num_i.ready),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .text_char_i (char_o.text_char),
  .last_i      (char_o.last)
);
